// ===== rtl/core/vgmnes_pkg.sv =====
// Shared types and constants for the VGM command stream parser (NES APU).
// No dependencies; imported by every module of the block.
package vgmnes_pkg;

    // VGM command bytes
    localparam logic [7:0] CMD_WAIT16   = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
    localparam logic [7:0] CMD_END      = 8'h66;
    localparam logic [7:0] CMD_BLOCK    = 8'h67;
    localparam logic [7:0] CMD_APU      = 8'hB4;
    localparam logic [7:0] BLOCK_MARKER = 8'h66;

    localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

    // RAM-write block type range
    localparam logic [7:0] BTYPE_RAM_LO = 8'hC0;
    localparam logic [7:0] BTYPE_RAM_HI = 8'hDF;

    localparam logic [7:0] APU_REG_SWEEP_ALIAS = 8'h3F;
    localparam logic [7:0] APU_ALIAS_TARGET    = 8'h23;
    localparam logic [7:0] APU_PAGE            = 8'h40;

    // Configuration register byte addresses
    localparam logic [2:0] ADDR_EMIT_PAYLOAD = 3'd0;
    localparam int         CFG_ADDR_W        = 3;

    typedef enum logic [3:0] {
        KIND_WAIT        = 4'd0,
        KIND_DONE        = 4'd1,
        KIND_APU_WRITE   = 4'd2,
        KIND_BLOCK_START = 4'd3,
        KIND_BLOCK_BYTE  = 4'd4,
        KIND_BAD_REG     = 4'd5,
        KIND_UNSUP_BLOCK = 4'd6,
        KIND_BAD_MARKER  = 4'd7,
        KIND_UNSUP_CMD   = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] wait_samples;
        logic [15:0] reg_address;
        logic [7:0]  reg_value;
        logic [15:0] block_address;
        logic [31:0] block_length;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [31:0] sample_position;
    } result_t;

endpackage

// ===== rtl/core/vgmnes_parse.sv =====
// Command decoder and parser state for the VGM stream parser.
// Uses vgmnes_pkg; one byte is consumed per accepted transfer.
module vgmnes_parse
    import vgmnes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  stream_byte,
    input  logic        restart,
    input  logic        emit_payload,
    output logic        res_valid,
    output result_t     res
);

    typedef enum logic [3:0] {
        PH_CMD,
        PH_WAIT16,
        PH_APU_REG,
        PH_APU_VAL,
        PH_MARKER,
        PH_BTYPE,
        PH_BLEN,
        PH_BADDR,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  gather_reg, gather_next;
    logic [7:0]  btype_reg, btype_next;
    logic [23:0] operand_reg, operand_next;
    logic [7:0]  addr_lo_reg, addr_lo_next;
    logic [15:0] ram_addr_reg, ram_addr_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] samples_reg, samples_next;
    logic        halted_reg, halted_next;

    logic [15:0] wait_n;
    logic        do_wait;
    logic [7:0]  apu_low;
    logic        apu_ok;
    logic [31:0] full_len;
    logic [31:0] pay_len;
    logic        last;

    // register byte mapping onto the APU page
    always_comb
    begin
        apu_ok  = 1'b1;
        apu_low = operand_reg[7:0];
        if (operand_reg[7]) begin
            apu_ok = 1'b0;
        end
        else if (operand_reg[7:0] == APU_REG_SWEEP_ALIAS) begin
            apu_low = APU_ALIAS_TARGET;
        end
        else if (operand_reg[7:5] == 3'b001) begin
            apu_low = operand_reg[7:0] + 8'h60;
        end
    end

    assign full_len = {stream_byte, operand_reg};
    assign pay_len  = (bytes_left_reg >= 32'd2) ? bytes_left_reg - 32'd2 : 32'd0;
    assign last     = (bytes_left_reg <= 32'd1);

    always_comb
    begin
        phase_next      = phase_reg;
        gather_next     = gather_reg;
        btype_next      = btype_reg;
        operand_next    = operand_reg;
        addr_lo_next    = addr_lo_reg;
        ram_addr_next   = ram_addr_reg;
        bytes_left_next = bytes_left_reg;
        halted_next     = halted_reg;
        wait_n          = '0;
        do_wait         = 1'b0;
        res_valid       = 1'b0;
        res             = '0;
        res.sample_position = samples_reg;

        if (accept) begin
            if (restart) begin
                phase_next   = PH_CMD;
                gather_next  = '0;
                operand_next = '0;
                halted_next  = 1'b0;
            end
            else if (!halted_reg) begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        gather_next  = '0;
                        operand_next = '0;
                        if (stream_byte == CMD_WAIT16) begin
                            phase_next = PH_WAIT16;
                        end
                        else if (stream_byte == CMD_WAIT_NTSC) begin
                            do_wait = 1'b1;
                            wait_n  = WAIT_NTSC_SAMPLES;
                        end
                        else if (stream_byte == CMD_WAIT_PAL) begin
                            do_wait = 1'b1;
                            wait_n  = WAIT_PAL_SAMPLES;
                        end
                        else if (stream_byte[7:4] == 4'h7) begin
                            do_wait = 1'b1;
                            wait_n  = {12'd0, stream_byte[3:0]} + 16'd1;
                        end
                        else if (stream_byte == CMD_END) begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_DONE;
                            halted_next = 1'b1;
                        end
                        else if (stream_byte == CMD_BLOCK) begin
                            phase_next = PH_MARKER;
                        end
                        else if (stream_byte == CMD_APU) begin
                            phase_next = PH_APU_REG;
                        end
                        else begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_UNSUP_CMD;
                            halted_next = 1'b1;
                        end
                    end
                    PH_WAIT16:
                    begin
                        gather_next = gather_reg + 2'd1;
                        if (gather_reg == 2'd0) begin
                            operand_next[7:0] = stream_byte;
                        end
                        else begin
                            phase_next = PH_CMD;
                            do_wait    = 1'b1;
                            wait_n     = {stream_byte, operand_reg[7:0]};
                        end
                    end
                    PH_APU_REG:
                    begin
                        operand_next = {16'd0, stream_byte};
                        phase_next   = PH_APU_VAL;
                    end
                    PH_APU_VAL:
                    begin
                        phase_next    = PH_CMD;
                        res_valid     = 1'b1;
                        res.reg_value = stream_byte;
                        if (apu_ok) begin
                            res.kind        = KIND_APU_WRITE;
                            res.reg_address = {APU_PAGE, apu_low};
                        end
                        else begin
                            res.kind = KIND_BAD_REG;
                        end
                    end
                    PH_MARKER:
                    begin
                        if (stream_byte != BLOCK_MARKER) begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_BAD_MARKER;
                            halted_next = 1'b1;
                            phase_next  = PH_CMD;
                        end
                        else begin
                            phase_next = PH_BTYPE;
                        end
                    end
                    PH_BTYPE:
                    begin
                        btype_next   = stream_byte;
                        gather_next  = '0;
                        operand_next = '0;
                        phase_next   = PH_BLEN;
                    end
                    PH_BLEN:
                    begin
                        gather_next = gather_reg + 2'd1;
                        case (gather_reg)
                            2'd0: operand_next[7:0]   = stream_byte;
                            2'd1: operand_next[15:8]  = stream_byte;
                            2'd2: operand_next[23:16] = stream_byte;
                            default:
                            begin
                                bytes_left_next = full_len;
                                if (btype_reg >= BTYPE_RAM_LO && btype_reg <= BTYPE_RAM_HI)
                                begin
                                    ram_addr_next = '0;
                                    phase_next    = PH_BADDR;
                                end
                                else begin
                                    res_valid        = 1'b1;
                                    res.kind         = KIND_UNSUP_BLOCK;
                                    res.block_length = full_len;
                                    phase_next = (full_len != 32'd0) ? PH_SKIP : PH_CMD;
                                end
                            end
                        endcase
                    end
                    PH_BADDR:
                    begin
                        gather_next = gather_reg + 2'd1;
                        if (gather_reg == 2'd0) begin
                            addr_lo_next = stream_byte;
                        end
                        else begin
                            ram_addr_next     = {stream_byte, addr_lo_reg};
                            bytes_left_next   = pay_len;
                            res_valid         = 1'b1;
                            res.kind          = KIND_BLOCK_START;
                            res.block_address = {stream_byte, addr_lo_reg};
                            res.block_length  = pay_len;
                            phase_next = (pay_len != 32'd0) ? PH_PAYLOAD : PH_CMD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        bytes_left_next = last ? 32'd0 : bytes_left_reg - 32'd1;
                        if (last) begin
                            phase_next = PH_CMD;
                        end
                        if (emit_payload) begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_BLOCK_BYTE;
                            res.block_address = ram_addr_reg;
                            res.payload_byte  = stream_byte;
                            res.last_byte     = last;
                        end
                    end
                    PH_SKIP:
                    begin
                        bytes_left_next = last ? 32'd0 : bytes_left_reg - 32'd1;
                        if (last) begin
                            phase_next = PH_CMD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end

        if (do_wait) begin
            res_valid        = 1'b1;
            res.kind         = KIND_WAIT;
            res.wait_samples = wait_n;
        end
    end

    always_comb
    begin
        samples_next = samples_reg;
        if (accept && restart) begin
            samples_next = '0;
        end
        else if (do_wait) begin
            samples_next = samples_reg + {16'd0, wait_n};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_CMD;
            gather_reg     <= '0;
            btype_reg      <= '0;
            operand_reg    <= '0;
            addr_lo_reg    <= '0;
            ram_addr_reg   <= '0;
            bytes_left_reg <= '0;
            samples_reg    <= '0;
            halted_reg     <= 1'b0;
        end
        else begin
            phase_reg      <= phase_next;
            gather_reg     <= gather_next;
            btype_reg      <= btype_next;
            operand_reg    <= operand_next;
            addr_lo_reg    <= addr_lo_next;
            ram_addr_reg   <= ram_addr_next;
            bytes_left_reg <= bytes_left_next;
            samples_reg    <= samples_next;
            halted_reg     <= halted_next;
        end
    end

    // payload and skip phases always have bytes outstanding
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD || phase_reg == PH_SKIP) |-> bytes_left_reg != 32'd0)
        else $error("payload phase with zero bytes left");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && !restart) |-> !res_valid)
        else $error("result produced while halted");

    a_done_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == KIND_DONE || res.kind == KIND_UNSUP_CMD
            || res.kind == KIND_BAD_MARKER)) |=> halted_reg)
        else $error("terminal result did not halt parser");

endmodule

// ===== rtl/core/vgmnes_out_reg.sv =====
// Result register for the VGM stream parser output channel.
// Uses vgmnes_pkg result_t; holds one result until the sink takes it.
module vgmnes_out_reg
    import vgmnes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/vgm_nes_command_parser.sv =====
// Top level of the VGM command stream parser for the NES APU.
// Uses vgmnes_pkg, vgmnes_parse and vgmnes_out_reg.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid, in_stall, stream_byte, restart   | sink
//  output    | out_valid, out_stall, kind .. sample_pos.  | source
//  config    | psel, penable, pwrite, paddr, pwdata, ...  | APB slave
//
// One byte per cycle: each byte is decoded in the cycle it is taken and its
// result, if any, lands in the output register on that edge.
// A byte is taken whenever the output register is empty or is being drained.
// Reset puts the parser at command start with a zero sample count and
// emit_payload set. A stalled result holds the input side until it moves.
module vgm_nes_command_parser
    import vgmnes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            stream_byte,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            kind,
    output logic [15:0]           wait_samples,
    output logic [15:0]           reg_address,
    output logic [7:0]            reg_value,
    output logic [15:0]           block_address,
    output logic [31:0]           block_length,
    output logic [7:0]            payload_byte,
    output logic                  last_byte,
    output logic [31:0]           sample_position
);

    logic    emit_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    sel_emit;

    assign pready   = 1'b1;
    assign sel_emit = (paddr[CFG_ADDR_W-1] == ADDR_EMIT_PAYLOAD[CFG_ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            emit_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && sel_emit) begin
            emit_reg <= pwdata[0];
        end
    end

    assign prdata = sel_emit ? {31'd0, emit_reg} : 32'd0;

    assign in_stall = out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    vgmnes_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .stream_byte  (stream_byte),
        .restart      (restart),
        .emit_payload (emit_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    vgmnes_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_res  (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign kind            = out_data.kind;
    assign wait_samples    = out_data.wait_samples;
    assign reg_address     = out_data.reg_address;
    assign reg_value       = out_data.reg_value;
    assign block_address   = out_data.block_address;
    assign block_length    = out_data.block_length;
    assign payload_byte    = out_data.payload_byte;
    assign last_byte       = out_data.last_byte;
    assign sample_position = out_data.sample_position;

endmodule

// ===== dv/vgm_nes_command_parser_tb.sv =====
// Self-checking testbench for vgm_nes_command_parser: byte stream in, parse results out.
// Depends on vgmnes_pkg and the RTL of the parser. Randomized valid/stall idling on
// both channels, emit_payload reprogrammed over APB between phases.
module vgm_nes_command_parser_tb;
    import vgmnes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASE_ITEMS = 325;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [7:0] CMD_WAIT_SHORT_LO = 8'h70;
    localparam logic [7:0] CMD_WAIT_SHORT_HI = 8'h7F;
    localparam logic [7:0] REG_DIRECT_HI = 8'h1F;
    localparam logic [7:0] REG_REMAP_LO = 8'h20;
    localparam logic [7:0] REG_REMAP_HI = 8'h3E;
    localparam logic [7:0] REG_HIGH_LO = 8'h40;
    localparam logic [7:0] REG_HIGH_HI = 8'h7F;
    localparam logic [7:0] REG_REMAP_BASE = 8'h80;

    typedef enum logic [3:0] {
        P_COMMAND, P_WAIT_COUNT, P_APU_REG, P_APU_DATA, P_MARKER,
        P_BLOCK_TYPE, P_LENGTH, P_ADDRESS, P_PAYLOAD, P_SKIP
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } stream_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = '0;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  kind;
    logic [15:0] wait_samples;
    logic [15:0] reg_address;
    logic [7:0]  reg_value;
    logic [15:0] block_address;
    logic [31:0] block_length;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] sample_position;

    vgm_nes_command_parser dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Parser model state
    parse_phase_t prs_phase = P_COMMAND;
    logic [2:0]   prs_gather = '0;
    logic [7:0]   prs_btype = '0;
    logic [31:0]  prs_operand = '0;
    logic [15:0]  prs_ram_addr = '0;
    logic [31:0]  prs_left = '0;
    logic [31:0]  prs_samples = '0;
    logic         prs_halted = 1'b0;
    logic         emit_cfg = 1'b1;

    stream_item_t pending_items[$];
    result_t      expected_results[$];
    int           errors = 0;
    int           items_fed = 0;
    int           cycles = 0;

    function automatic result_t new_result(input kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        r.sample_position = prs_samples;
        return r;
    endfunction

    function automatic void add_wait(input logic [15:0] n);
        result_t r;
        r = new_result(KIND_WAIT);
        r.wait_samples = n;
        expected_results.push_back(r);
        prs_samples = prs_samples + {16'd0, n};
    endfunction

    // Advance the parser model by one accepted transfer
    function automatic void parse_byte(input logic [7:0] b, input logic rs);
        result_t    r;
        logic [7:0] reg_id;
        logic [7:0] low;
        logic       last;
        if (rs) begin
            prs_phase = P_COMMAND;
            prs_gather = '0;
            prs_operand = '0;
            prs_samples = '0;
            prs_halted = 1'b0;
            return;
        end
        if (prs_halted)
            return;
        case (prs_phase)
            P_COMMAND:
            begin
                prs_gather = '0;
                prs_operand = '0;
                if (b == CMD_WAIT16)
                    prs_phase = P_WAIT_COUNT;
                else if (b == CMD_WAIT_NTSC)
                    add_wait(WAIT_NTSC_SAMPLES);
                else if (b == CMD_WAIT_PAL)
                    add_wait(WAIT_PAL_SAMPLES);
                else if (b >= CMD_WAIT_SHORT_LO && b <= CMD_WAIT_SHORT_HI)
                    add_wait({12'd0, b[3:0]} + 16'd1);
                else if (b == CMD_END) begin
                    expected_results.push_back(new_result(KIND_DONE));
                    prs_halted = 1'b1;
                end
                else if (b == CMD_BLOCK)
                    prs_phase = P_MARKER;
                else if (b == CMD_APU)
                    prs_phase = P_APU_REG;
                else begin
                    expected_results.push_back(new_result(KIND_UNSUP_CMD));
                    prs_halted = 1'b1;
                end
            end
            P_WAIT_COUNT:
            begin
                prs_operand[8*prs_gather[0] +: 8] = b;
                prs_gather = prs_gather + 3'd1;
                if (prs_gather == 3'd2) begin
                    prs_phase = P_COMMAND;
                    add_wait(prs_operand[15:0]);
                end
            end
            P_APU_REG:
            begin
                prs_operand = {24'd0, b};
                prs_phase = P_APU_DATA;
            end
            P_APU_DATA:
            begin
                reg_id = prs_operand[7:0];
                prs_phase = P_COMMAND;
                if (reg_id <= REG_DIRECT_HI || (reg_id >= REG_HIGH_LO && reg_id <= REG_HIGH_HI))
                    low = reg_id;
                else if (reg_id >= REG_REMAP_LO && reg_id <= REG_REMAP_HI)
                    low = REG_REMAP_BASE + (reg_id - REG_REMAP_LO);
                else if (reg_id == APU_REG_SWEEP_ALIAS)
                    low = APU_ALIAS_TARGET;
                else begin
                    r = new_result(KIND_BAD_REG);
                    r.reg_value = b;
                    expected_results.push_back(r);
                    return;
                end
                r = new_result(KIND_APU_WRITE);
                r.reg_address = {APU_PAGE, low};
                r.reg_value = b;
                expected_results.push_back(r);
            end
            P_MARKER:
            begin
                if (b != BLOCK_MARKER) begin
                    expected_results.push_back(new_result(KIND_BAD_MARKER));
                    prs_halted = 1'b1;
                    prs_phase = P_COMMAND;
                end
                else
                    prs_phase = P_BLOCK_TYPE;
            end
            P_BLOCK_TYPE:
            begin
                prs_btype = b;
                prs_gather = '0;
                prs_operand = '0;
                prs_phase = P_LENGTH;
            end
            P_LENGTH:
            begin
                prs_operand[8*prs_gather[1:0] +: 8] = b;
                prs_gather = prs_gather + 3'd1;
                if (prs_gather == 3'd4) begin
                    prs_left = prs_operand;
                    prs_gather = '0;
                    if (prs_btype >= BTYPE_RAM_LO && prs_btype <= BTYPE_RAM_HI) begin
                        prs_ram_addr = '0;
                        prs_phase = P_ADDRESS;
                    end
                    else begin
                        r = new_result(KIND_UNSUP_BLOCK);
                        r.block_length = prs_left;
                        expected_results.push_back(r);
                        prs_phase = (prs_left != 0) ? P_SKIP : P_COMMAND;
                    end
                end
            end
            P_ADDRESS:
            begin
                prs_ram_addr[8*prs_gather[0] +: 8] = b;
                prs_gather = prs_gather + 3'd1;
                if (prs_gather == 3'd2) begin
                    prs_left = (prs_left >= 2) ? prs_left - 32'd2 : 32'd0;
                    r = new_result(KIND_BLOCK_START);
                    r.block_address = prs_ram_addr;
                    r.block_length = prs_left;
                    expected_results.push_back(r);
                    prs_phase = (prs_left != 0) ? P_PAYLOAD : P_COMMAND;
                end
            end
            P_PAYLOAD:
            begin
                last = (prs_left <= 1);
                prs_left = last ? 32'd0 : prs_left - 32'd1;
                if (last)
                    prs_phase = P_COMMAND;
                if (emit_cfg) begin
                    r = new_result(KIND_BLOCK_BYTE);
                    r.block_address = prs_ram_addr;
                    r.payload_byte = b;
                    r.last_byte = last;
                    expected_results.push_back(r);
                end
            end
            P_SKIP:
            begin
                prs_left = (prs_left <= 1) ? 32'd0 : prs_left - 32'd1;
                if (prs_left == 0)
                    prs_phase = P_COMMAND;
            end
            default:
                prs_phase = P_COMMAND;
        endcase
    endfunction

    // Sender: one transfer per pending item, random gaps and gap-free stretches
    int gap_left = 0;
    int calm_in = 0;

    always @(posedge clk)
    begin
        int pick;
        stream_item_t it;
        if (rst_n) begin
            if (in_valid && !in_stall)
                parse_byte(stream_byte, restart);
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    stream_byte <= it.data;
                    restart <= it.restart;
                    if (calm_in > 0)
                        calm_in <= calm_in - 1;
                    else begin
                        pick = $urandom_range(0, 99);
                        if (pick >= 96)
                            calm_in <= $urandom_range(20, 80);
                        else if (pick >= 88)
                            gap_left <= $urandom_range(4, 25);
                        else if (pick >= 65)
                            gap_left <= $urandom_range(1, 3);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall runs, mostly short
    int stall_left = 0;
    int calm_out = 0;

    always @(posedge clk)
    begin
        int pick;
        if (rst_n) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (calm_out > 0) begin
                calm_out <= calm_out - 1;
                out_stall <= 1'b0;
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    out_stall <= 1'b0;
                else if (pick < 85) begin
                    out_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                else if (pick < 95) begin
                    out_stall <= 1'b1;
                    stall_left <= $urandom_range(5, 30);
                end
                else begin
                    out_stall <= 1'b0;
                    calm_out <= $urandom_range(20, 80);
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d",
                         $time, kind);
                errors++;
            end
            else begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("wait_samples", 32'(want.wait_samples), 32'(wait_samples));
                check_field("reg_address", 32'(want.reg_address), 32'(reg_address));
                check_field("reg_value", 32'(want.reg_value), 32'(reg_value));
                check_field("block_address", 32'(want.block_address), 32'(block_address));
                check_field("block_length", want.block_length, block_length);
                check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
                check_field("last_byte", 32'(want.last_byte), 32'(last_byte));
                check_field("sample_position", want.sample_position, sample_position);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void feed_byte(input logic [7:0] b);
        stream_item_t it;
        it.data = b;
        it.restart = 1'b0;
        pending_items.push_back(it);
        items_fed++;
    endfunction

    function automatic void feed_restart();
        stream_item_t it;
        it.data = 8'($urandom);
        it.restart = 1'b1;
        pending_items.push_back(it);
        items_fed++;
    endfunction

    function automatic void feed_block_header(input logic [7:0] btype, input logic [31:0] len);
        feed_byte(CMD_BLOCK);
        feed_byte(BLOCK_MARKER);
        feed_byte(btype);
        for (int i = 0; i < 4; i++)
            feed_byte(len[8*i +: 8]);
    endfunction

    function automatic void queue_random_command();
        int          sel;
        int          n;
        logic [7:0]  t;
        logic [31:0] len;
        logic [15:0] addr;
        sel = $urandom_range(0, 99);
        if (sel < 14) begin
            feed_byte(CMD_WAIT16);
            feed_byte(8'($urandom));
            feed_byte(8'($urandom));
        end
        else if (sel < 22)
            feed_byte(CMD_WAIT_NTSC);
        else if (sel < 30)
            feed_byte(CMD_WAIT_PAL);
        else if (sel < 42)
            feed_byte(CMD_WAIT_SHORT_LO + 8'($urandom_range(0, 15)));
        else if (sel < 66) begin
            feed_byte(CMD_APU);
            if ($urandom_range(0, 9) == 0)
                feed_byte(8'($urandom_range(8'h80, 8'hFF)));
            else
                feed_byte(8'($urandom_range(0, 8'h7F)));
            feed_byte(8'($urandom));
        end
        else if (sel < 86) begin
            t = 8'($urandom_range(BTYPE_RAM_LO, BTYPE_RAM_HI));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            addr = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
            feed_block_header(t, len);
            feed_byte(addr[7:0]);
            feed_byte(addr[15:8]);
            for (int i = 2; i < len; i++)
                feed_byte(8'($urandom));
        end
        else if (sel < 91) begin
            do t = 8'($urandom); while (t inside {[BTYPE_RAM_LO:BTYPE_RAM_HI]});
            len = $urandom_range(0, 6);
            feed_block_header(t, len);
            for (int i = 0; i < len; i++)
                feed_byte(8'($urandom));
        end
        else if (sel < 94) begin
            // huge length, cut short by a restart
            t = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(BTYPE_RAM_LO, BTYPE_RAM_HI))
                                            : 8'($urandom);
            feed_block_header(t, $urandom);
            if (t inside {[BTYPE_RAM_LO:BTYPE_RAM_HI]}) begin
                feed_byte(8'($urandom));
                feed_byte(8'($urandom));
            end
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                feed_byte(8'($urandom));
            feed_restart();
        end
        else if (sel < 96) begin
            case ($urandom_range(0, 2))
                0: feed_byte(CMD_WAIT16);
                1: feed_byte(CMD_APU);
                default: feed_byte(CMD_BLOCK);
            endcase
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                feed_byte(8'($urandom));
            feed_restart();
        end
        else if (sel < 98) begin
            case ($urandom_range(0, 2))
                0: feed_byte(CMD_END);
                1:
                begin
                    feed_byte(CMD_BLOCK);
                    do t = 8'($urandom); while (t == BLOCK_MARKER);
                    feed_byte(t);
                end
                default:
                begin
                    do t = 8'($urandom);
                    while (t inside {CMD_WAIT16, CMD_WAIT_NTSC, CMD_WAIT_PAL, CMD_END,
                                     CMD_BLOCK, CMD_APU,
                                     [CMD_WAIT_SHORT_LO:CMD_WAIT_SHORT_HI]});
                    feed_byte(t);
                end
            endcase
            // ignored while halted
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                feed_byte(8'($urandom));
            feed_restart();
        end
        else
            feed_restart();
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        // bytes that give no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_emit_payload(input logic v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_EMIT_PAYLOAD;
        pwdata <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        emit_cfg = v;
    endtask

    task automatic run_random_phase(input logic emit);
        int stop_at;
        write_emit_payload(emit);
        stop_at = items_fed + PHASE_ITEMS;
        while (items_fed < stop_at)
            queue_random_command();
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: emit_payload at its reset value
        feed_restart();
        feed_byte(CMD_WAIT16); feed_byte(8'h00); feed_byte(8'h00);
        feed_byte(CMD_WAIT16); feed_byte(8'hFF); feed_byte(8'hFF);
        feed_byte(CMD_WAIT_NTSC); feed_byte(CMD_WAIT_PAL);
        feed_byte(CMD_WAIT_SHORT_LO); feed_byte(CMD_WAIT_SHORT_HI);
        feed_byte(CMD_APU); feed_byte(8'h00); feed_byte(8'hFF);
        feed_byte(CMD_APU); feed_byte(APU_REG_SWEEP_ALIAS); feed_byte(8'h00);
        feed_byte(CMD_APU); feed_byte(REG_REMAP_LO); feed_byte(8'h5A);
        feed_byte(CMD_APU); feed_byte(REG_REMAP_HI); feed_byte(8'hA5);
        feed_byte(CMD_APU); feed_byte(REG_HIGH_LO); feed_byte(8'h01);
        feed_byte(CMD_APU); feed_byte(REG_HIGH_HI); feed_byte(8'h02);
        feed_byte(CMD_APU); feed_byte(8'h80); feed_byte(8'h03);
        feed_byte(CMD_APU); feed_byte(8'hFF); feed_byte(8'h04);
        // block at address zero with three payload bytes
        feed_block_header(BTYPE_RAM_LO, 32'd5);
        feed_byte(8'h00); feed_byte(8'h00);
        feed_byte(8'h11); feed_byte(8'h22); feed_byte(8'h33);
        // short block: stored length below two
        feed_block_header(BTYPE_RAM_HI, 32'd1);
        feed_byte(8'h34); feed_byte(8'h12);
        // unsupported blocks, skipped and empty
        feed_block_header(8'h00, 32'd3);
        feed_byte(CMD_END); feed_byte(8'hFF); feed_byte(8'h00);
        feed_block_header(8'hFF, 32'd0);
        feed_byte(CMD_END); feed_byte(8'h00);
        feed_restart();
        feed_byte(CMD_BLOCK); feed_byte(8'h00); feed_byte(CMD_APU);
        feed_restart();
        feed_byte(8'h00); feed_byte(8'hFF);
        feed_restart();
        feed_byte(8'hFF);
        feed_restart();
        wait_idle();

        run_random_phase(1'b0);
        run_random_phase(1'b1);
        run_random_phase(1'b0);
        run_random_phase(1'b1);

        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else begin
            if (expected_results.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         expected_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
